// ===== rtl/ihp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image header probe package
// Shared constants, format codes and the result record.
// ----------------------------------------------------------------------------
package ihp_pkg;

  // Number of leading file bytes kept for format classification.
  localparam int HdrBytes = 32;
  localparam int CntW     = $clog2(HdrBytes + 1);

  typedef logic [HdrBytes-1:0][7:0] hdr_t;

  typedef enum logic [2:0] {
    FmtUnknown = 3'd0,
    FmtJpeg    = 3'd1,
    FmtPng     = 3'd2,
    FmtGif     = 3'd3,
    FmtWebp    = 3'd4,
    FmtBmp     = 3'd5,
    FmtAvif    = 3'd6,
    FmtHeif    = 3'd7
  } img_fmt_e;

  typedef struct packed {
    img_fmt_e           fmt;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic               corrupt;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/image_header_probe_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image header probe core
// Sniffs the format of an image file streamed as bytes and finds its size.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_stall_o    data_byte_i, last_byte_i
//  out      output     out_valid_o / out_stall_i  image_format_o, image_width_o,
//                                                 image_height_o, corrupt_o
//
// One byte is taken every cycle unless in_stall_o is high; the result of a file
// is decided in the cycle its deciding byte is transferred and is written into the queue.
// Results wait in a two-entry queue; in_stall_o rises only when it is full.
// Reset clears all control state; the header bytes are kept without reset.
// ----------------------------------------------------------------------------
module image_header_probe_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         image_format_o,
  output logic signed [31:0] image_width_o,
  output logic signed [31:0] image_height_o,
  output logic               corrupt_o
);
  import ihp_pkg::*;

  logic    push, full;
  result_t push_data, out_data;

  ihp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .full_i      (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ihp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign in_stall_o     = full;
  assign image_format_o = out_data.fmt;
  assign image_width_o  = out_data.width;
  assign image_height_o = out_data.height;
  assign corrupt_o      = out_data.corrupt;

endmodule
`default_nettype wire

// ===== rtl/ihp_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image header probe classifier
// Decides the non-JPEG formats from the stored header bytes and a byte count.
// ----------------------------------------------------------------------------
module ihp_classify (
  input  ihp_pkg::hdr_t        hdr_i,
  input  logic [ihp_pkg::CntW-1:0] n_i,
  output ihp_pkg::result_t     res_o
);
  import ihp_pkg::*;

  logic        png_sig, ihdr, gif_sig, riff, webp, bmp_sig, ftyp;
  logic [31:0] brand;
  logic [31:0] vp8l_bits;
  logic [31:0] w, h;
  logic        bad;
  img_fmt_e    fmt;

  assign png_sig = {hdr_i[0], hdr_i[1], hdr_i[2], hdr_i[3],
                    hdr_i[4], hdr_i[5], hdr_i[6], hdr_i[7]} == 64'h89504E470D0A1A0A;
  assign ihdr    = {hdr_i[12], hdr_i[13], hdr_i[14], hdr_i[15]} == 32'h49484452;
  assign gif_sig = {hdr_i[0], hdr_i[1], hdr_i[2]} == 24'h474946;
  assign riff    = {hdr_i[0], hdr_i[1], hdr_i[2], hdr_i[3]} == 32'h52494646;
  assign webp    = {hdr_i[8], hdr_i[9], hdr_i[10], hdr_i[11]} == 32'h57454250;
  assign bmp_sig = {hdr_i[0], hdr_i[1]} == 16'h424D;
  assign ftyp    = {hdr_i[4], hdr_i[5], hdr_i[6], hdr_i[7]} == 32'h66747970;
  assign brand   = {hdr_i[8], hdr_i[9], hdr_i[10], hdr_i[11]};
  assign vp8l_bits = {hdr_i[24], hdr_i[23], hdr_i[22], hdr_i[21]};

  always_comb begin
    fmt = FmtUnknown;
    w   = '0;
    h   = '0;
    bad = 1'b0;
    if (n_i >= CntW'(8) && png_sig) begin
      fmt = FmtPng;
      if (n_i >= CntW'(24) && ihdr) begin
        w = {hdr_i[16], hdr_i[17], hdr_i[18], hdr_i[19]};
        h = {hdr_i[20], hdr_i[21], hdr_i[22], hdr_i[23]};
      end else begin
        bad = 1'b1;
      end
    end else if (n_i >= CntW'(3) && gif_sig) begin
      fmt = FmtGif;
      if (n_i >= CntW'(10)) begin
        w = {16'h0, hdr_i[7], hdr_i[6]};
        h = {16'h0, hdr_i[9], hdr_i[8]};
      end else begin
        bad = 1'b1;
      end
    end else if (n_i >= CntW'(12) && riff && webp) begin
      fmt = FmtWebp;
      if (n_i < CntW'(30)) begin
        bad = 1'b1;
      end else begin
        case ({hdr_i[12], hdr_i[13], hdr_i[14], hdr_i[15]})
          32'h56503858: begin
            w = {8'h0, hdr_i[26], hdr_i[25], hdr_i[24]} + 32'd1;
            h = {8'h0, hdr_i[29], hdr_i[28], hdr_i[27]} + 32'd1;
          end
          32'h5650384C: begin
            w = {18'h0, vp8l_bits[13:0]} + 32'd1;
            h = {18'h0, vp8l_bits[27:14]} + 32'd1;
          end
          32'h56503820: begin
            w = {18'h0, hdr_i[27][5:0], hdr_i[26]};
            h = {18'h0, hdr_i[29][5:0], hdr_i[28]};
          end
          default: ;
        endcase
        if (w == 32'd0 || h == 32'd0) bad = 1'b1;
      end
    end else if (n_i >= CntW'(2) && bmp_sig) begin
      fmt = FmtBmp;
      if (n_i >= CntW'(26)) begin
        w = {hdr_i[21], hdr_i[20], hdr_i[19], hdr_i[18]};
        h = {hdr_i[25], hdr_i[24], hdr_i[23], hdr_i[22]};
      end else begin
        bad = 1'b1;
      end
    end else if (n_i >= CntW'(12) && ftyp) begin
      case (brand)
        32'h61766966, 32'h61766973: fmt = FmtAvif;
        32'h68656963, 32'h68656978, 32'h68657663, 32'h68657678,
        32'h6865696D, 32'h68656973, 32'h6D696631, 32'h6D736631: fmt = FmtHeif;
        default: fmt = FmtUnknown;
      endcase
    end
    if (fmt != FmtUnknown && (w[31] || h[31])) bad = 1'b1;
  end

  assign res_o.fmt     = fmt;
  assign res_o.width   = w;
  assign res_o.height  = h;
  assign res_o.corrupt = bad;

endmodule
`default_nettype wire

// ===== rtl/ihp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image header probe front end
// Accepts file bytes, keeps the header, walks JPEG markers and decides results.
// ----------------------------------------------------------------------------
module ihp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             full_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             push_o,
  output ihp_pkg::result_t push_data_o
);
  import ihp_pkg::*;

  typedef enum logic [5:0] {
    PhPrefix = 6'b000001,
    PhMarker = 6'b000010,
    PhLenHi  = 6'b000100,
    PhLenLo  = 6'b001000,
    PhSkip   = 6'b010000,
    PhFrame  = 6'b100000
  } phase_e;

  function automatic logic is_sof(input logic [7:0] m);
    is_sof = m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
  endfunction

  hdr_t            hdr_q, view;
  logic [CntW-1:0] cnt_q, cnt_d, n_cnt;
  phase_e          phase_q, phase_d, w_phase;
  logic [15:0]     seg_q, seg_d, w_seg, seg_len, seg_dec;
  logic [7:0]      mark_q, mark_d, w_mark;
  logic [15:0]     fh_q, fh_d, w_fh, fw_q, fw_d, w_fw;
  logic            given_q, given_d;
  logic            fire, wr, jpeg, walk_done, walk_bad, emit;
  result_t         cls_res, res;

  assign fire = in_valid_i && !full_i;
  assign wr   = cnt_q < CntW'(HdrBytes);

  always_comb begin
    for (int i = 0; i < HdrBytes; i++) begin
      view[i] = (wr && cnt_q == CntW'(i)) ? data_byte_i : hdr_q[i];
    end
  end

  assign n_cnt = wr ? cnt_q + CntW'(1) : cnt_q;
  assign jpeg  = n_cnt >= CntW'(3) && view[0] == 8'hFF && view[1] == 8'hD8 &&
                 view[2] == 8'hFF;

  ihp_classify u_classify (
    .hdr_i (view),
    .n_i   (n_cnt),
    .res_o (cls_res)
  );

  assign seg_len = {seg_q[15:8], data_byte_i};
  assign seg_dec = seg_q - 16'd1;

  // One byte of the marker walk.
  always_comb begin
    w_phase   = phase_q;
    w_seg     = seg_q;
    w_mark    = mark_q;
    w_fh      = fh_q;
    w_fw      = fw_q;
    walk_done = 1'b0;
    walk_bad  = 1'b0;
    case (phase_q)
      PhPrefix: begin
        if (data_byte_i == 8'hFF) w_phase = PhMarker;
      end
      PhMarker: begin
        if (data_byte_i == 8'hD9 || data_byte_i == 8'hDA) begin
          walk_bad = 1'b1;
        end else if (data_byte_i != 8'hFF) begin
          w_mark  = data_byte_i;
          w_phase = PhLenHi;
        end
      end
      PhLenHi: begin
        w_seg   = {data_byte_i, 8'h00};
        w_phase = PhLenLo;
      end
      PhLenLo: begin
        w_seg = seg_len;
        if (seg_len < 16'd2) begin
          walk_bad = 1'b1;
        end else if (is_sof(mark_q)) begin
          w_seg   = '0;
          w_phase = PhFrame;
        end else begin
          w_seg   = seg_len - 16'd2;
          w_phase = (seg_len == 16'd2) ? PhPrefix : PhSkip;
        end
      end
      PhSkip: begin
        w_seg = seg_dec;
        if (seg_dec == 16'd0) w_phase = PhPrefix;
      end
      PhFrame: begin
        case (seg_q)
          16'd1:   w_fh[15:8] = data_byte_i;
          16'd2:   w_fh[7:0]  = data_byte_i;
          16'd3:   w_fw[15:8] = data_byte_i;
          16'd4:   w_fw[7:0]  = data_byte_i;
          default: ;
        endcase
        w_seg     = seg_q + 16'd1;
        walk_done = seg_q >= 16'd4;
      end
      default: w_phase = PhPrefix;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    phase_d = phase_q;
    seg_d   = seg_q;
    mark_d  = mark_q;
    fh_d    = fh_q;
    fw_d    = fw_q;
    given_d = given_q;
    emit    = 1'b0;
    res     = cls_res;
    if (fire && !given_q) begin
      cnt_d = n_cnt;
      if (jpeg) begin
        phase_d = w_phase;
        seg_d   = w_seg;
        mark_d  = w_mark;
        fh_d    = w_fh;
        fw_d    = w_fw;
        res.fmt = FmtJpeg;
        if (walk_done) begin
          res.width   = {16'h0, w_fw};
          res.height  = {16'h0, w_fh};
          res.corrupt = 1'b0;
        end else begin
          res.width   = '0;
          res.height  = '0;
          res.corrupt = 1'b1;
        end
        emit = walk_done || walk_bad || last_byte_i;
      end else begin
        emit = n_cnt >= CntW'(HdrBytes) || last_byte_i;
      end
      if (emit && !last_byte_i) given_d = 1'b1;
    end
    // The final byte of a file always starts the next one from scratch.
    if (fire && last_byte_i) begin
      cnt_d   = '0;
      phase_d = PhPrefix;
      seg_d   = '0;
      mark_d  = '0;
      fh_d    = '0;
      fw_d    = '0;
      given_d = 1'b0;
    end
  end

  assign push_o      = emit;
  assign push_data_o = res;

  always_ff @(posedge clk_i) begin
    if (fire && !given_q) hdr_q <= view;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= PhPrefix;
      seg_q   <= '0;
      mark_q  <= '0;
      fh_q    <= '0;
      fw_q    <= '0;
      given_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      seg_q   <= seg_d;
      mark_q  <= mark_d;
      fh_q    <= fh_d;
      fw_q    <= fw_d;
      given_q <= given_d;
    end
  end

  a_no_push_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q |-> !push_o) else $error("result pushed twice for one file");

  a_given_after_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !last_byte_i) |=> given_q) else $error("early result not recorded");

  a_restart_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_byte_i) |=> (cnt_q == '0 && !given_q))
    else $error("new file did not restart");

endmodule
`default_nettype wire

// ===== rtl/ihp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image header probe result queue
// Two-entry result queue whose head register drives the output channel.
// ----------------------------------------------------------------------------
module ihp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ihp_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ihp_pkg::result_t out_data_o
);
  import ihp_pkg::*;

  result_t     mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign full_o      = cnt_q == 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q + 2'd1 == $past(cnt_q)))
    else $error("queue count wrong after pop");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image header probe testbench
// Streams image files (JPEG marker walks, PNG, GIF, WebP, BMP, AVIF, HEIF and
// noise) into the core with random gaps and output stalls, predicts each
// file's format and size, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ihp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic last_byte_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, corrupt_o;
  logic [2:0] image_format_o;
  logic signed [31:0] image_width_o, image_height_o;

  image_header_probe_core i_dut (.*);

  always #2 clk_i = ~clk_i;

  byte_item_t pending_bytes[$];
  result_t    expected_results[$];
  int         error_count = 0;

  // Predictor state for the file currently streaming in.
  logic [7:0]  hdr_q[HdrBytes];
  int          hdr_cnt;
  int          walk_phase;
  logic [15:0] seg_cnt;
  logic [7:0]  cur_marker;
  logic [15:0] frame_h, frame_w;
  bit          decided;

  task automatic start_file();
    hdr_cnt = 0; walk_phase = 0; seg_cnt = 0; cur_marker = 0;
    frame_h = 0; frame_w = 0; decided = 0;
  endtask

  function automatic bit hdr_is(int off, string s);
    for (int i = 0; i < s.len(); i++)
      if (hdr_q[off+i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic logic [31:0] le_bytes(int off, int n);
    logic [31:0] v = 0;
    for (int i = n - 1; i >= 0; i--) v = (v << 8) | hdr_q[off+i];
    return v;
  endfunction

  function automatic logic [31:0] be_word(int off);
    return {hdr_q[off], hdr_q[off+1], hdr_q[off+2], hdr_q[off+3]};
  endfunction

  // Returns 0 to continue, 1 when the frame size is complete, 2 on corrupt.
  function automatic int jpeg_step(logic [7:0] b);
    case (walk_phase)
      0: begin
        if (b == 8'hFF) walk_phase = 1;
        return 0;
      end
      1: begin
        if (b == 8'hFF) return 0;
        if (b == 8'hD9 || b == 8'hDA) return 2;
        cur_marker = b; walk_phase = 2;
        return 0;
      end
      2: begin
        seg_cnt = {b, 8'h00}; walk_phase = 3;
        return 0;
      end
      3: begin
        seg_cnt[7:0] = b;
        if (seg_cnt < 2) return 2;
        if (cur_marker >= 8'hC0 && cur_marker <= 8'hCF && cur_marker != 8'hC4 &&
            cur_marker != 8'hC8 && cur_marker != 8'hCC) begin
          seg_cnt = 0; walk_phase = 5;
        end else begin
          seg_cnt -= 2;
          walk_phase = (seg_cnt == 0) ? 0 : 4;
        end
        return 0;
      end
      4: begin
        seg_cnt -= 1;
        if (seg_cnt == 0) walk_phase = 0;
        return 0;
      end
      default: begin
        case (seg_cnt)
          1: frame_h[15:8] = b;
          2: frame_h[7:0] = b;
          3: frame_w[15:8] = b;
          4: frame_w[7:0] = b;
          default: ;
        endcase
        seg_cnt += 1;
        return (seg_cnt >= 5) ? 1 : 0;
      end
    endcase
  endfunction

  function automatic result_t classify_header(int n);
    result_t r;
    logic [31:0] w = 0, h = 0, bits;
    string heif_brands[8] = '{"heic", "heix", "hevc", "hevx", "heim", "heis",
                              "mif1", "msf1"};
    r = '0;
    r.fmt = FmtUnknown;
    if (n >= 8 && hdr_q[0] == 8'h89 && hdr_is(1, "PNG") && hdr_q[4] == 8'h0D &&
        hdr_q[5] == 8'h0A && hdr_q[6] == 8'h1A && hdr_q[7] == 8'h0A) begin
      r.fmt = FmtPng;
      if (n >= 24 && hdr_is(12, "IHDR")) begin
        w = be_word(16); h = be_word(20);
      end else r.corrupt = 1;
    end else if (n >= 3 && hdr_is(0, "GIF")) begin
      r.fmt = FmtGif;
      if (n >= 10) begin
        w = le_bytes(6, 2); h = le_bytes(8, 2);
      end else r.corrupt = 1;
    end else if (n >= 12 && hdr_is(0, "RIFF") && hdr_is(8, "WEBP")) begin
      r.fmt = FmtWebp;
      if (n < 30) begin
        r.corrupt = 1;
        return r;
      end
      if (hdr_is(12, "VP8X")) begin
        w = le_bytes(24, 3) + 1; h = le_bytes(27, 3) + 1;
      end else if (hdr_is(12, "VP8L")) begin
        bits = le_bytes(21, 4);
        w = (bits & 32'h3FFF) + 1; h = ((bits >> 14) & 32'h3FFF) + 1;
      end else if (hdr_is(12, "VP8 ")) begin
        w = le_bytes(26, 2) & 32'h3FFF; h = le_bytes(28, 2) & 32'h3FFF;
      end
      if (w == 0 || h == 0) r.corrupt = 1;
    end else if (n >= 2 && hdr_is(0, "BM")) begin
      r.fmt = FmtBmp;
      if (n >= 26) begin
        w = le_bytes(18, 4); h = le_bytes(22, 4);
      end else r.corrupt = 1;
    end else if (n >= 12 && hdr_is(4, "ftyp")) begin
      if (hdr_is(8, "avif") || hdr_is(8, "avis")) r.fmt = FmtAvif;
      else foreach (heif_brands[i]) if (hdr_is(8, heif_brands[i])) r.fmt = FmtHeif;
    end
    if (r.fmt != FmtUnknown && (w[31] || h[31])) r.corrupt = 1;
    r.width = w; r.height = h;
    return r;
  endfunction

  task automatic predict_byte(byte_item_t it);
    result_t r;
    bit emit = 0;
    int st;
    if (decided) begin
      if (it.last) start_file();
      return;
    end
    if (hdr_cnt < HdrBytes) begin
      hdr_q[hdr_cnt] = it.data; hdr_cnt++;
    end
    r = '0;
    if (hdr_cnt >= 3 && hdr_q[0] == 8'hFF && hdr_q[1] == 8'hD8 && hdr_q[2] == 8'hFF) begin
      st = jpeg_step(it.data);
      r.fmt = FmtJpeg;
      if (st == 1) begin
        r.width = {16'h0, frame_w}; r.height = {16'h0, frame_h}; emit = 1;
      end else if (st == 2 || it.last) begin
        r.corrupt = 1; emit = 1;
      end
    end else if (hdr_cnt >= HdrBytes || it.last) begin
      r = classify_header(hdr_cnt); emit = 1;
    end
    if (emit) expected_results.push_back(r);
    if (it.last) start_file();
    else if (emit) decided = 1;
  endtask

  // ---- stimulus construction ----
  task automatic put_bytes(byte unsigned f[$]);
    foreach (f[i]) pending_bytes.push_back('{f[i], i == f.size() - 1});
  endtask

  function automatic void put_str(ref byte unsigned f[$], input string s);
    for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
  endfunction

  function automatic void put_rand(ref byte unsigned f[$], input int n);
    repeat (n) f.push_back($urandom_range(0, 255));
  endfunction

  function automatic void put_le(ref byte unsigned f[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) f.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_be(ref byte unsigned f[$], input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) f.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(1, 4000);
      default: return $urandom;
    endcase
  endfunction

  // Builds one file of the given kind; a random cut truncates some of them.
  task automatic make_file(int kind, bit cut);
    byte unsigned f[$];
    byte unsigned t[$];
    int nseg;
    logic [7:0] m;
    case (kind)
      0: begin
        f = '{8'hFF, 8'hD8};
        nseg = $urandom_range(0, 3);
        repeat (nseg) begin
          repeat ($urandom_range(0, 2)) f.push_back($urandom_range(0, 255));
          repeat ($urandom_range(1, 3)) f.push_back(8'hFF);
          case ($urandom_range(0, 5))
            0: m = 8'hC4;
            1: m = 8'hC8;
            2: m = 8'hCC;
            default: m = $urandom_range(8'hE0, 8'hFE);
          endcase
          f.push_back(m);
          t.delete(); put_rand(t, $urandom_range(0, 6));
          put_be(f, t.size() + 2, 2);
          f = {f, t};
        end
        f.push_back(8'hFF);
        case ($urandom_range(0, 9))
          0: begin
            f.push_back($urandom_range(0, 1) ? 8'hD9 : 8'hDA);
          end
          1: begin
            f.push_back(8'hE1); put_be(f, $urandom_range(0, 1), 2);
          end
          default: begin
            do m = $urandom_range(8'hC0, 8'hCF);
            while (m == 8'hC4 || m == 8'hC8 || m == 8'hCC);
            f.push_back(m);
            put_be(f, $urandom_range(0, 1) ? 17 : $urandom_range(0, 65535), 2);
            f.push_back(8);
            put_be(f, $urandom_range(0, 1) ? $urandom_range(0, 65535) : 16'hFFFF, 2);
            put_be(f, $urandom_range(0, 1) ? $urandom_range(0, 65535) : 16'h0000, 2);
          end
        endcase
        put_rand(f, $urandom_range(0, 5));
      end
      1: begin
        f = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        put_be(f, 13, 4);
        put_str(f, $urandom_range(0, 7) ? "IHDR" : "IHDX");
        put_be(f, rand_dim(), 4); put_be(f, rand_dim(), 4);
        put_rand(f, $urandom_range(0, 20));
      end
      2: begin
        put_str(f, $urandom_range(0, 1) ? "GIF89a" : "GIF87a");
        put_le(f, rand_dim(), 2); put_le(f, rand_dim(), 2);
        put_rand(f, $urandom_range(0, 30));
      end
      3: begin
        put_str(f, "RIFF"); put_rand(f, 4); put_str(f, "WEBP");
        case ($urandom_range(0, 3))
          0: put_str(f, "VP8X");
          1: put_str(f, "VP8L");
          2: put_str(f, "VP8 ");
          default: put_str(f, "VP9Z");
        endcase
        put_rand(f, 18);
        if ($urandom_range(0, 3) == 0) for (int i = 21; i < 30; i++) f[i] = 0;
        if ($urandom_range(0, 3) == 0) for (int i = 21; i < 30; i++) f[i] = 8'hFF;
        put_rand(f, $urandom_range(0, 10));
      end
      4: begin
        put_str(f, "BM"); put_rand(f, 16);
        put_le(f, rand_dim(), 4); put_le(f, rand_dim(), 4);
        put_rand(f, $urandom_range(0, 12));
      end
      5: begin
        string brands[10] = '{"avif", "avis", "heic", "heix", "hevc", "hevx",
                              "heim", "heis", "mif1", "msf1"};
        put_be(f, 32'h18, 4); put_str(f, "ftyp");
        if ($urandom_range(0, 5) == 0) put_str(f, "isom");
        else put_str(f, brands[$urandom_range(0, 9)]);
        put_rand(f, $urandom_range(0, 30));
      end
      default: begin
        put_rand(f, $urandom_range(1, 40));
        if ($urandom_range(0, 1)) f[0] = 8'hFF;
      end
    endcase
    if (cut && f.size() > 1) f = f[0:$urandom_range(0, f.size() - 2)];
    put_bytes(f);
  endtask

  // ---- driver: bursts and gaps ----
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    byte_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) predict_byte('{data_byte_i, last_byte_i});
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        it = pending_bytes.pop_front();
        data_byte_i <= it.data;
        last_byte_i <= it.last;
        in_valid_i <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) ? $urandom_range(5, 60) : 0;
          gap_left = burst_left ? $urandom_range(0, 4) : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---- receiver stall pattern, with one long hold-off ----
  int hold_cycles = 0, cycle_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycle_cnt++;
      if (cycle_cnt == 600) hold_cycles = 400;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if ((cycle_cnt / 500) % 3 == 1) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 9) < 4);
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result fmt=%0d w=%0d h=%0d corrupt=%0b", $time,
                 image_format_o, image_width_o, image_height_o, corrupt_o);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (image_format_o !== e.fmt) begin
          $display("%0t: format expected %0d actual %0d", $time, e.fmt, image_format_o);
          error_count++;
        end
        if (image_width_o !== e.width) begin
          $display("%0t: width expected %0d actual %0d", $time, e.width, image_width_o);
          error_count++;
        end
        if (image_height_o !== e.height) begin
          $display("%0t: height expected %0d actual %0d", $time, e.height, image_height_o);
          error_count++;
        end
        if (corrupt_o !== e.corrupt) begin
          $display("%0t: corrupt expected %0b actual %0b", $time, e.corrupt, corrupt_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    byte unsigned f[$];
    start_file();
    // Directed: one file of each generator kind, a bare last byte, short and empty-ish files.
    for (int k = 0; k <= 6; k++) make_file(k, 1'b0);
    f = '{8'hFF, 8'hD8, 8'hFF, 8'hD9}; put_bytes(f);
    f = '{8'h00}; put_bytes(f);
    f = '{8'h42, 8'h4D}; put_bytes(f);
    while (pending_bytes.size() < 1350)
      make_file($urandom_range(0, 7) < 3 ? 0 : $urandom_range(0, 6),
                $urandom_range(0, 5) == 0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
